[src/rtc3_pkg.sv]
// Shared types, constants and BCD helpers for the three-wire RTC serial master.
// No dependencies; imported by the front end, queue, transfer engine and top level.
package rtc3_pkg;

	localparam int CMD_BITS  = 8;
	localparam int DATA_BITS = 8;
	localparam int NUM_BITS  = CMD_BITS + DATA_BITS;
	localparam int CNT_W     = $clog2(2 * NUM_BITS);
	localparam int QDEPTH    = 4;
	localparam int QAW       = $clog2(QDEPTH);
	localparam int QCW       = $clog2(QDEPTH + 1);

	localparam logic [CNT_W-1:0] LAST_CNT   = CNT_W'(2 * NUM_BITS - 1);
	localparam logic [CNT_W-1:0] FIRST_DATA = CNT_W'(2 * CMD_BITS);
	localparam logic [6:0]       MAX_DEC    = 7'd99;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BITS,
		ST_TAIL,
		ST_DONE
	} rtc3_state_t;

	// one classified tick, as it sits in the queue
	typedef struct packed {
		logic                  start;
		logic                  is_read;
		logic [NUM_BITS-1:0]   word;     // [7:0] command, [15:8] BCD data
		logic                  sda_in;
	} rtc3_item_t;

	// one tick of pin levels, lowest field last
	typedef struct packed {
		logic [7:0] read_value;
		logic       done_res;
		logic       busy_res;
		logic       sda_drive;
		logic       sda_out;
		logic       sck_level;
		logic       rst_level;
	} rtc3_res_t;

	// clamp to 99 and split into two BCD digits; tens by reciprocal 205/2048
	function automatic logic [7:0] to_bcd(input logic [6:0] val);
		logic [6:0]  v;
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  tmul;
		logic [6:0]  ones;
		v    = (val > MAX_DEC) ? MAX_DEC : val;
		prod = 15'(v) * 15'd205;
		tens = prod[14:11];
		tmul = {tens, 3'b000} + {2'b00, tens, 1'b0};
		ones = v - tmul;
		return {tens, ones[3:0]};
	endfunction

	// high nibble times ten plus low nibble
	function automatic logic [7:0] from_bcd(input logic [7:0] b);
		return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
	endfunction

endpackage

[src/rtc3_front.sv]
// Front end: accepts input items and classifies them into queue entries.
// Depends on rtc3_pkg.
module rtc3_front import rtc3_pkg::*; (
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic               start_req,
	input  logic               operation,
	input  logic [7:0]         command,
	input  logic [6:0]         write_value,
	input  logic               sda_in,
	input  logic               q_full,
	output logic               q_push,
	output rtc3_item_t         q_item
);

	logic [7:0] cmd_fixed;

	// bit 0 of the command carries the direction
	assign cmd_fixed = {command[7:1], operation};

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_item.start   = start_req;
		q_item.is_read = operation;
		q_item.word    = {to_bcd(write_value), cmd_fixed};
		q_item.sda_in  = sda_in;
	end

endmodule

[src/rtc3_fifo.sv]
// Short queue between front end and transfer engine.
// Depends on rtc3_pkg.
module rtc3_fifo import rtc3_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  rtc3_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       nonempty,
	output rtc3_item_t head
);

	rtc3_item_t         mem_q [QDEPTH];
	logic [QAW-1:0]     wr_ptr_q;
	logic [QAW-1:0]     rd_ptr_q;
	logic [QCW-1:0]     count_q;

	assign full     = (count_q == QCW'(QDEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/rtc3_back.sv]
// Transfer engine: runs one tick per queue entry and holds the result register.
// Depends on rtc3_pkg.
module rtc3_back import rtc3_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_nonempty,
	input  rtc3_item_t q_head,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output rtc3_res_t  res
);

	rtc3_state_t          state_q, state_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [NUM_BITS-1:0]  shift_out_q;
	logic                 is_read_q;
	logic [7:0]           shift_in_q;
	logic                 read_bit;
	logic                 sample;
	rtc3_res_t            res_d;
	rtc3_res_t            res_q;
	logic                 out_valid_q;

	assign q_pop    = q_nonempty && (!out_valid_q || m_tready);
	assign read_bit = is_read_q && (cnt_q >= FIRST_DATA);
	assign sample   = (state_q == ST_BITS) && read_bit && !cnt_q[0];

	// next state
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (q_head.start) begin
					state_d = ST_BITS;
					cnt_d   = '0;
				end
			end
			ST_BITS: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == LAST_CNT) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// pin levels for this tick
	always_comb begin
		res_d = '0;
		res_d.sda_drive = 1'b1;
		case (state_q)
			ST_IDLE: res_d.busy_res = q_head.start;
			ST_BITS: begin
				res_d.rst_level = 1'b1;
				res_d.sck_level = cnt_q[0];
				res_d.busy_res  = 1'b1;
				if (read_bit) begin
					res_d.sda_drive = 1'b0;
				end else begin
					res_d.sda_out = shift_out_q[cnt_q[CNT_W-1:1]];
				end
			end
			ST_TAIL: begin
				res_d.rst_level = 1'b1;
				res_d.busy_res  = 1'b1;
			end
			ST_DONE: begin
				res_d.busy_res   = 1'b1;
				res_d.done_res   = 1'b1;
				res_d.read_value = is_read_q ? from_bcd(shift_in_q) : 8'd0;
			end
			default: res_d.sda_drive = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			shift_out_q <= '0;
			is_read_q   <= 1'b0;
			shift_in_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				state_q <= state_d;
				cnt_q   <= cnt_d;
				if (state_q == ST_IDLE && q_head.start) begin
					shift_out_q <= q_head.word;
					is_read_q   <= q_head.is_read;
					shift_in_q  <= '0;
				end else if (sample) begin
					shift_in_q <= {q_head.sda_in, shift_in_q[7:1]};
				end
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign res      = res_q;

endmodule

[src/three_wire_rtc_serial_master.sv]
// Top level of the three-wire RTC serial master.
// Depends on rtc3_pkg, rtc3_front, rtc3_fifo and rtc3_back.
//
// Usage:
//   Each input item on the s_ channel is one pin-level tick. An item with
//   start_req set on an idle tick begins a single-register transfer: RST low
//   for the start tick, then 16 bits (command LSB first, then BCD data or
//   eight sampled read bits), two ticks per bit with SCK low then high, a
//   tail tick with SCK low, and a done tick with RST low and done_res set.
//   A whole transfer spans 35 ticks; start_req is ignored while busy.
//   Each input item yields exactly one result item on the m_ channel with
//   the pin levels of that tick and, on the done tick of a read, the
//   converted value.
// Throughput and path:
//   One item per clock sustained while m_tready stays high. An accepted
//   item is written to the queue at the accepting edge and then loaded
//   into the result register, from which the result is presented.
// Reset:
//   arst_n clears the queue, the engine state and the result valid flag;
//   the engine starts idle.
// Stalls:
//   When m_tready is low a presented result holds; the four-entry queue
//   keeps accepting until full, then s_tready drops.
module three_wire_rtc_serial_master import rtc3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] start_req, [8:1] command, [15:9] write_value, [16] sda_in, rest zero
	input  logic [23:0] s_tdata,
	// [0] operation
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] rst_level, [1] sck_level, [2] sda_out, [3] sda_drive,
	// [4] busy_res, [5] done_res, [13:6] read_value, rest zero
	output logic [15:0] m_tdata
);

	logic       q_full;
	logic       q_push;
	logic       q_pop;
	logic       q_nonempty;
	rtc3_item_t q_item;
	rtc3_item_t q_head;
	rtc3_res_t  res;

	rtc3_front u_front (
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.start_req   (s_tdata[0]),
		.operation   (s_tuser),
		.command     (s_tdata[8:1]),
		.write_value (s_tdata[15:9]),
		.sda_in      (s_tdata[16]),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (q_item)
	);

	rtc3_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	rtc3_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.res        (res)
	);

	// result fields are packed lowest first; pad to two bytes
	assign m_tdata = {2'b00, res};

endmodule

[src/rtc3_checker.sv]
// Port-level checks for the three-wire RTC serial master, bound to the top level.
// Depends on three_wire_rtc_serial_master.
module rtc3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// done tick is part of the busy window
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[5] |-> m_tdata[4])
		else $error("done without busy");

	// read value only on a done tick
	a_rval_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[5] |-> m_tdata[13:6] == 8'd0)
		else $error("read value outside done tick");

	// data line released only inside an enabled transfer
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[3] |-> m_tdata[0] && m_tdata[4] && !m_tdata[2])
		else $error("data line released outside transfer");

	// SCK high only while RST is high
	a_sck_rst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[0])
		else $error("SCK high with RST low");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind three_wire_rtc_serial_master rtc3_checker u_rtc3_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[tb/sv/rtc3_tb_pkg.sv]
`timescale 1ns / 100ps
// Pin-level scoreboard for the three-wire RTC serial master testbench.
// Depends on rtc3_pkg for the result layout; used by three_wire_rtc_serial_master_tb.
package rtc3_tb_pkg;
	import rtc3_pkg::*;

	localparam bit       OP_WRITE      = 1'b0;
	localparam bit       OP_READ       = 1'b1;
	localparam bit [5:0] PH_IDLE       = 6'd0;
	localparam bit [5:0] PH_FIRST_READ = 6'd17;
	localparam bit [5:0] PH_LAST_BIT   = 6'd32;
	localparam bit [5:0] PH_TAIL       = 6'd33;
	localparam bit [5:0] PH_DONE       = 6'd34;
	localparam bit [7:0] READ_FLAG     = 8'h01;
	localparam bit [7:0] WRITE_MASK    = 8'hFE;
	localparam bit [6:0] DEC_MAX       = 7'd99;
	localparam int       REPORT_MAX    = 10;

	class pin_level_scoreboard;
		rtc3_res_t expected_pins[$];
		bit [5:0]  phase;
		bit [15:0] frame;    // [7:0] command, [15:8] BCD value
		bit        reading;
		bit [7:0]  sampled;
		int        errors;
		int        checked;
		int        writes;
		int        reads;

		function bit [7:0] dec_to_bcd(bit [6:0] v);
			bit [6:0] c;
			c = (v > DEC_MAX) ? DEC_MAX : v;
			return {4'(c / 10), 4'(c % 10)};
		endfunction

		// pin levels for one tick, advancing the transfer state
		function rtc3_res_t predict_pins(bit start, bit op, bit [7:0] cmd, bit [6:0] wval,
				bit sda);
			rtc3_res_t r;
			bit [3:0]  idx;
			bit        rise;
			bit [7:0]  cb;
			r = '0;
			r.sda_drive = 1'b1;
			if (phase == PH_IDLE) begin
				if (start) begin
					reading = (op == OP_READ);
					cb = reading ? (cmd | READ_FLAG) : (cmd & WRITE_MASK);
					frame = {dec_to_bcd(wval), cb};
					sampled = '0;
					r.busy_res = 1'b1;
					phase = 6'd1;
					if (reading)
						reads++;
					else
						writes++;
				end
			end else if (phase <= PH_LAST_BIT) begin
				idx = 4'((phase - 6'd1) >> 1);
				rise = ~phase[0];
				r.rst_level = 1'b1;
				r.sck_level = rise;
				r.busy_res = 1'b1;
				if (reading && idx >= 4'd8) begin
					r.sda_drive = 1'b0;
					if (!rise)
						sampled = {sda, sampled[7:1]};
				end else begin
					r.sda_out = frame[idx];
				end
				phase++;
			end else if (phase == PH_TAIL) begin
				r.rst_level = 1'b1;
				r.busy_res = 1'b1;
				phase = PH_DONE;
			end else if (phase == PH_DONE) begin
				r.busy_res = 1'b1;
				r.done_res = 1'b1;
				if (reading)
					r.read_value = 8'(sampled[7:4]) * 8'd10 + 8'(sampled[3:0]);
				phase = PH_IDLE;
			end else begin
				phase = PH_IDLE;
			end
			return r;
		endfunction

		function void note_tick(bit start, bit op, bit [7:0] cmd, bit [6:0] wval, bit sda);
			expected_pins.push_back(predict_pins(start, op, cmd, wval, sda));
		endfunction

		function int pending();
			return expected_pins.size();
		endfunction

		function void cmp_field(string name, logic [7:0] want, logic [7:0] seen);
			if (seen !== want) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("mismatch on result %0d, %s: expected %0d, got %0d",
						checked, name, want, seen);
			end
		endfunction

		function void check_pins(logic [15:0] data);
			rtc3_res_t want;
			rtc3_res_t seen;
			if (expected_pins.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("result %h arrived with nothing expected", data);
				return;
			end
			want = expected_pins.pop_front();
			seen = data[13:0];
			cmp_field("rst_level", 8'(want.rst_level), 8'(seen.rst_level));
			cmp_field("sck_level", 8'(want.sck_level), 8'(seen.sck_level));
			cmp_field("sda_out", 8'(want.sda_out), 8'(seen.sda_out));
			cmp_field("sda_drive", 8'(want.sda_drive), 8'(seen.sda_drive));
			cmp_field("busy_res", 8'(want.busy_res), 8'(seen.busy_res));
			cmp_field("done_res", 8'(want.done_res), 8'(seen.done_res));
			cmp_field("read_value", want.read_value, seen.read_value);
			cmp_field("padding", 8'd0, 8'(data[15:14]));
			checked++;
		endfunction
	endclass

endpackage

[tb/sv/three_wire_rtc_serial_master_tb.sv]
`timescale 1ns / 100ps
// Top-level testbench for three_wire_rtc_serial_master: drives pin ticks, checks pin levels.
// Depends on rtc3_pkg, rtc3_tb_pkg and the block's RTL.
module three_wire_rtc_serial_master_tb;
	import rtc3_pkg::*;
	import rtc3_tb_pkg::*;

	localparam int RANDOM_TICKS   = 250;
	localparam int WATCHDOG_LIMIT = 2000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	pin_level_scoreboard sb = new();

	// when set, both sides run back to back with no idle cycles
	bit rush;
	int ticks_sent;
	int stalled;

	three_wire_rtc_serial_master DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// One tick item. Called at a rising edge; returns at the edge that accepted it,
	// with s_tvalid still high so a back-to-back item needs no second assignment.
	task automatic send_tick(input bit start, input bit op, input bit [7:0] cmd,
			input bit [6:0] wval, input bit sda);
		int gap;
		gap = rush ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		// tdata: [0] start_req, [8:1] command, [15:9] write_value, [16] sda_in
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, sda, wval, cmd, start};
		s_tuser  <= op;
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_tick(start, op, cmd, wval, sda);
		ticks_sent++;
	endtask

	// idle tick: no start, every other field random
	task automatic idle_tick();
		send_tick(1'b0, 1'($urandom_range(0, 1)), 8'($urandom), 7'($urandom),
			1'($urandom_range(0, 1)));
	endtask

	// Start tick plus the 34 ticks of the transfer. For a read, the data line carries
	// rd_byte LSB first on the SCK-low tick of each read bit. With noisy set, the
	// busy ticks carry random start requests and fields, which must be ignored.
	task automatic run_transfer(input bit op, input bit [7:0] cmd, input bit [6:0] wval,
			input bit [7:0] rd_byte, input bit noisy);
		bit dline;
		send_tick(1'b1, op, cmd, wval, 1'($urandom_range(0, 1)));
		for (int k = 1; k <= PH_DONE; k++) begin
			dline = 1'($urandom_range(0, 1));
			if (op == OP_READ && k >= PH_FIRST_READ && k <= PH_LAST_BIT && k[0])
				dline = rd_byte[(k - PH_FIRST_READ) >> 1];
			if (noisy)
				send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					8'($urandom), 7'($urandom), dline);
			else
				send_tick(1'b0, op, cmd, wval, dline);
		end
	endtask

	// hold the sender off until every outstanding result has been seen
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// result side: random stalls, check each accepted item
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = rush ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			sb.check_pins(m_tdata);
		end
	end

	// no handshake on either side for too long means a hang
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stalled <= 0;
		end else if (stalled >= WATCHDOG_LIMIT) begin
			$display("timeout: no item moved for %0d cycles, %0d results outstanding",
				stalled, sb.pending());
			$display("FAIL three_wire_rtc_serial_master");
			$finish;
		end else begin
			stalled <= stalled + 1;
		end
	end

	initial begin : stimulus
		int directed_ticks;
		int n_idle;
		bit [6:0] wv;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: forced R/W bit on all-ones and all-zero commands, BCD extremes,
		// clamping above 99, start requests while busy, full-scale and zero reads.
		run_transfer(OP_WRITE, 8'hFF, 7'd127, 8'h00, 1'b0);
		run_transfer(OP_WRITE, 8'h00, 7'd0, 8'h00, 1'b1);
		idle_tick();
		run_transfer(OP_WRITE, 8'h5A, 7'd99, 8'h00, 1'b0);
		run_transfer(OP_WRITE, 8'hA5, 7'd100, 8'h00, 1'b1);
		run_transfer(OP_READ, 8'h00, 7'd0, 8'hFF, 1'b0);
		run_transfer(OP_READ, 8'hFE, 7'd127, 8'h00, 1'b1);
		run_transfer(OP_READ, 8'hFF, 7'd55, 8'h99, 1'b0);
		drain_results();
		directed_ticks = ticks_sent;

		// Random: mostly complete transfers with random content, a few idle ticks
		// between them, occasional no-idle bursts and full drains.
		while (ticks_sent - directed_ticks < RANDOM_TICKS) begin
			rush = ($urandom_range(0, 3) == 0);
			n_idle = $urandom_range(0, 3);
			repeat (n_idle) idle_tick();
			wv = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(100, 127))
				: 7'($urandom_range(0, 99));
			run_transfer(1'($urandom_range(0, 1)), 8'($urandom), wv, 8'($urandom),
				1'($urandom_range(0, 1)));
			if ($urandom_range(0, 4) == 0)
				drain_results();
		end
		rush = 1'b0;

		drain_results();
		repeat (6) @(posedge clk);

		$display("covered %0d ticks: %0d writes and %0d reads started, %0d results checked",
			ticks_sent, sb.writes, sb.reads, sb.checked);
		$display("mismatches: %0d, results left over: %0d", sb.errors, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS three_wire_rtc_serial_master");
		else
			$display("FAIL three_wire_rtc_serial_master");
		$finish;
	end

endmodule
